### src/bpto_pkg.sv
// Shared types, widths and sequencer states for the bone parent ordering block.
`timescale 1ns / 1ps

package bpto_pkg;

    localparam int MAX_BONES_DEF = 64;
    localparam int PARENT_W      = 7;
    localparam int BONE_W        = 6;

    typedef struct packed {
        logic signed [PARENT_W-1:0] parent_index;
        logic                       last_bone;
    } t_in_word;

    typedef struct packed {
        logic [BONE_W-1:0] bone_index;
        logic              last_result;
    } t_out_word;

    // Parent table port: one write and one read address per cycle.
    typedef struct packed {
        logic                we;
        logic [BONE_W-1:0]   waddr;
        logic [PARENT_W-1:0] wdata;
        logic                re;
        logic [BONE_W-1:0]   raddr;
    } t_pmem_req;

    // Ancestor stack port.
    typedef struct packed {
        logic              we;
        logic [BONE_W-1:0] waddr;
        logic [BONE_W-1:0] wdata;
        logic              re;
        logic [BONE_W-1:0] raddr;
    } t_smem_req;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_NEXT,
        ST_CHECK,
        ST_PARENT,
        ST_POP,
        ST_EMIT
    } t_state;

endpackage

### src/bpto_parent_mem.sv
// Parent table: synchronous memory holding one parent index per loaded bone.
`timescale 1ns / 1ps

module bpto_parent_mem #(
    parameter int MAX_BONES = bpto_pkg::MAX_BONES_DEF
) (
    input  logic                          i_clk,
    input  bpto_pkg::t_pmem_req           i_req,
    output logic [bpto_pkg::PARENT_W-1:0] o_rdata
);
    import bpto_pkg::*;

    localparam int IDX_W = $clog2(MAX_BONES);

    logic [PARENT_W-1:0] r_mem [MAX_BONES];
    logic [PARENT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[IDX_W-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[IDX_W-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bpto_stack_mem.sv
// Ancestor stack: synchronous memory of bones waiting to be emitted.
`timescale 1ns / 1ps

module bpto_stack_mem #(
    parameter int MAX_BONES = bpto_pkg::MAX_BONES_DEF
) (
    input  logic                        i_clk,
    input  bpto_pkg::t_smem_req         i_req,
    output logic [bpto_pkg::BONE_W-1:0] o_rdata
);
    import bpto_pkg::*;

    localparam int IDX_W = $clog2(MAX_BONES);

    logic [BONE_W-1:0] r_mem [MAX_BONES];
    logic [BONE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[IDX_W-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[IDX_W-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bpto_walker.sv
// Sequencer: loads bones, walks ancestors, pops the stack and drives the output register.
`timescale 1ns / 1ps

module bpto_walker #(
    parameter int MAX_BONES = bpto_pkg::MAX_BONES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  bpto_pkg::t_in_word            i_in_data,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output bpto_pkg::t_out_word           o_out_data,
    input  logic                          i_out_ready,
    output bpto_pkg::t_pmem_req           o_preq,
    input  logic [bpto_pkg::PARENT_W-1:0] i_prdata,
    output bpto_pkg::t_smem_req           o_sreq,
    input  logic [bpto_pkg::BONE_W-1:0]   i_srdata
);
    import bpto_pkg::*;

    localparam int IDX_W = $clog2(MAX_BONES);
    localparam int CNT_W = $clog2(MAX_BONES + 1);

    t_state               r_state,   n_state;
    logic [CNT_W-1:0]     r_loaded,  n_loaded;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic [CNT_W-1:0]     r_outer,   n_outer;
    logic [CNT_W-1:0]     r_depth,   n_depth;
    logic [CNT_W-1:0]     r_emitted, n_emitted;
    logic [IDX_W-1:0]     r_cur,     n_cur;
    logic [MAX_BONES-1:0] r_visited, n_visited;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out,     n_out;

    logic             in_acc;
    logic             has_room;
    logic             parent_root;
    logic [CNT_W-1:0] depth_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_loaded    <= '0;
            r_count     <= '0;
            r_outer     <= '0;
            r_depth     <= '0;
            r_emitted   <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_count     <= n_count;
            r_outer     <= n_outer;
            r_depth     <= n_depth;
            r_emitted   <= n_emitted;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign has_room    = (r_loaded < CNT_W'(MAX_BONES));
    assign depth_dec   = r_depth - CNT_W'(1);
    // Negative or not below the loaded count: treat as root.
    assign parent_root = i_prdata[PARENT_W-1]
                      || ({1'b0, i_prdata[BONE_W-1:0]} >= PARENT_W'(r_count));

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_count     = r_count;
        n_outer     = r_outer;
        n_depth     = r_depth;
        n_emitted   = r_emitted;
        n_cur       = r_cur;
        n_visited   = r_visited;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_preq      = '0;
        o_sreq      = '0;

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        o_preq.we    = 1'b1;
                        o_preq.waddr = BONE_W'(r_loaded[IDX_W-1:0]);
                        o_preq.wdata = i_in_data.parent_index;
                        n_loaded     = r_loaded + CNT_W'(1);
                    end
                    if (i_in_data.last_bone) begin
                        n_count   = has_room ? r_loaded + CNT_W'(1) : r_loaded;
                        n_outer   = '0;
                        n_emitted = '0;
                        n_state   = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                if (r_outer == r_count) begin
                    // Set finished: drop marks and start an empty set.
                    n_visited = '0;
                    n_loaded  = '0;
                    n_depth   = '0;
                    n_state   = ST_LOAD;
                end else begin
                    n_cur   = r_outer[IDX_W-1:0];
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_visited[r_cur]) begin
                    n_state = ST_POP;
                end else begin
                    n_visited[r_cur] = 1'b1;
                    o_sreq.we        = 1'b1;
                    o_sreq.waddr     = BONE_W'(r_depth[IDX_W-1:0]);
                    o_sreq.wdata     = BONE_W'(r_cur);
                    n_depth          = r_depth + CNT_W'(1);
                    o_preq.re        = 1'b1;
                    o_preq.raddr     = BONE_W'(r_cur);
                    n_state          = ST_PARENT;
                end
            end
            ST_PARENT: begin
                if (parent_root) begin
                    n_state = ST_POP;
                end else begin
                    n_cur   = i_prdata[IDX_W-1:0];
                    n_state = ST_CHECK;
                end
            end
            ST_POP: begin
                if (r_depth == '0) begin
                    n_outer = r_outer + CNT_W'(1);
                    n_state = ST_NEXT;
                end else begin
                    o_sreq.re    = 1'b1;
                    o_sreq.raddr = BONE_W'(depth_dec[IDX_W-1:0]);
                    n_depth      = depth_dec;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold the popped bone until the output register frees up.
                if (!r_out_valid || i_out_ready) begin
                    n_out.bone_index  = i_srdata;
                    n_out.last_result = ((r_emitted + CNT_W'(1)) == r_count);
                    n_out_valid       = 1'b1;
                    n_emitted         = r_emitted + CNT_W'(1);
                    n_state           = ST_POP;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/bone_parent_topological_order_unit.sv
// Top level: parent-before-child ordering of a bone forest loaded one bone per word.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready   | parent_index, last_bone
//  out     | output    | o_out_valid / i_out_ready | bone_index, last_result
//
// Loading accepts one word per cycle; o_in_ready is low while a set is being ordered.
// Ordering pushes each ancestor in a mark step (visited mark, stack write and parent
// table read) followed by a parent step, pops each bone with a stack memory read and
// then an output register load, and adds an outer cursor step and a visited check per
// bone; the parent table and ancestor stack memories both have registered reads.
// Reset is synchronous and clears the sequencer, counts and visited marks; the
// memories are not cleared. A stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps

module bone_parent_topological_order_unit #(
    parameter int MAX_BONES = bpto_pkg::MAX_BONES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bpto_pkg::t_in_word  i_in_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bpto_pkg::t_out_word o_out_data,
    input  logic                i_out_ready
);
    import bpto_pkg::*;

    t_pmem_req           preq;
    t_smem_req           sreq;
    logic [PARENT_W-1:0] prdata;
    logic [BONE_W-1:0]   srdata;

    bpto_walker #(
        .MAX_BONES(MAX_BONES)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_ready(i_out_ready),
        .o_preq     (preq),
        .i_prdata   (prdata),
        .o_sreq     (sreq),
        .i_srdata   (srdata)
    );

    bpto_parent_mem #(
        .MAX_BONES(MAX_BONES)
    ) u_parent_mem (
        .i_clk  (i_clk),
        .i_req  (preq),
        .o_rdata(prdata)
    );

    bpto_stack_mem #(
        .MAX_BONES(MAX_BONES)
    ) u_stack_mem (
        .i_clk  (i_clk),
        .i_req  (sreq),
        .o_rdata(srdata)
    );

`ifndef NO_ASSERTIONS
    a_pwrite_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        preq.we |-> (i_in_valid && o_in_ready))
        else $error("parent table written without an accepted word");

    a_pmem_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(preq.we && preq.re))
        else $error("parent table loaded and walked in the same cycle");

    a_smem_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sreq.we && sreq.re))
        else $error("ancestor stack pushed and popped in the same cycle");

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.last_bone) |=> !o_in_ready)
        else $error("input still open after the final bone of a set");
`endif

endmodule
